### rtl/avs_pkg.sv
// ----------------------------------------------------------------------------
// avs_pkg
// Shared widths, defaults and cell control type for the ascending value sorter.
// ----------------------------------------------------------------------------
package avs_pkg;

    // element width
    localparam int WORD_W = 32;

    // default number of cells in the chain
    localparam int CAPACITY_DEF = 64;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;   // insert the broadcast value
        logic emit;   // shift the chain towards the head
    } cell_ctrl_t;

endpackage

### rtl/avs_cell.sv
// ----------------------------------------------------------------------------
// avs_cell
// One cell of the sorting chain: holds one element and its valid bit.
// ----------------------------------------------------------------------------
module avs_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  avs_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [avs_pkg::WORD_W-1:0]   din,
    input  logic signed [avs_pkg::WORD_W-1:0]   prev_val,
    input  logic                                prev_valid,
    input  logic                                prev_lt,
    input  logic signed [avs_pkg::WORD_W-1:0]   next_val,
    input  logic                                next_valid,
    output logic signed [avs_pkg::WORD_W-1:0]   val,
    output logic                                valid,
    output logic                                lt
);

    logic signed [avs_pkg::WORD_W-1:0] val_reg;
    logic signed [avs_pkg::WORD_W-1:0] val_next;
    logic                              valid_reg;
    logic                              valid_next;

    // empty cells count as greater than any value
    assign lt = !valid_reg || (din < val_reg);

    // insertion takes the new value or the neighbour's, emission pulls from the tail side
    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.emit)
        begin
            val_next   = next_val;
            valid_next = next_valid;
        end
        else if (ctrl.load && lt)
        begin
            if (prev_lt)
            begin
                val_next   = prev_val;
                valid_next = prev_valid;
            end
            else
            begin
                val_next   = din;
                valid_next = 1'b1;
            end
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // element payload
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

### rtl/ascending_value_sorter.sv
// The first result is offered in the cycle after the batch-ending transaction.
// Throughput: one input transaction per cycle while loading, one result per cycle
//   while emitting and out_ready is high.
// Loading stalls from the batch-ending transaction until the last result is taken.
// Insertion and emission are each a single registered step of the whole cell chain.
// Reset clears the cell valid bits, the state and the overflow flag.
// ----------------------------------------------------------------------------
// ascending_value_sorter
// Batch sorter built as a chain of insertion cells kept in ascending order.
// ----------------------------------------------------------------------------
module ascending_value_sorter #(
    parameter int CAPACITY = avs_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [avs_pkg::WORD_W-1:0]   value,
    input  logic                                batch_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [avs_pkg::WORD_W-1:0]   sorted_value,
    output logic                                final_result,
    output logic                                overflowed
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                               state_reg;
    logic                               state_next;
    logic                               overflow_reg;
    logic                               overflow_next;
    avs_pkg::cell_ctrl_t                ctrl;
    logic                               in_fire;
    logic                               out_fire;
    logic                               full;

    logic signed [avs_pkg::WORD_W-1:0]  cell_val   [CAPACITY];
    logic [CAPACITY-1:0]                cell_valid;
    logic [CAPACITY-1:0]                cell_lt;
    logic signed [avs_pkg::WORD_W-1:0]  prev_val   [CAPACITY];
    logic [CAPACITY-1:0]                prev_valid;
    logic [CAPACITY-1:0]                prev_lt;
    logic signed [avs_pkg::WORD_W-1:0]  next_val   [CAPACITY];
    logic [CAPACITY-1:0]                next_valid;

    // handshakes
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (state_reg == ST_EMIT) && cell_valid[0];
    assign out_fire  = out_valid && out_ready;
    assign full      = cell_valid[CAPACITY-1];

    // chain commands; a transaction into a full chain is dropped
    assign ctrl.load = in_fire && !full;
    assign ctrl.emit = out_fire;

    // neighbour wiring and cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign prev_val[gi]   = '0;
                assign prev_valid[gi] = 1'b0;
                assign prev_lt[gi]    = 1'b0;
            end
            else
            begin : g_body
                assign prev_val[gi]   = cell_val[gi-1];
                assign prev_valid[gi] = cell_valid[gi-1];
                assign prev_lt[gi]    = cell_lt[gi-1];
            end

            if (gi == CAPACITY-1)
            begin : g_tail
                assign next_val[gi]   = '0;
                assign next_valid[gi] = 1'b0;
            end
            else
            begin : g_inner
                assign next_val[gi]   = cell_val[gi+1];
                assign next_valid[gi] = cell_valid[gi+1];
            end

            avs_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .din        (value),
                .prev_val   (prev_val[gi]),
                .prev_valid (prev_valid[gi]),
                .prev_lt    (prev_lt[gi]),
                .next_val   (next_val[gi]),
                .next_valid (next_valid[gi]),
                .val        (cell_val[gi]),
                .valid      (cell_valid[gi]),
                .lt         (cell_lt[gi])
            );
        end
    endgenerate

    // result payload comes straight from the head cell
    assign sorted_value = cell_val[0];
    assign final_result = cell_valid[0] && !cell_valid[1];
    assign overflowed   = overflow_reg;

    // load / emit sequencing and overflow tracking
    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && full)
                begin
                    overflow_next = 1'b1;
                end
                if (in_fire && batch_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_fire && final_result)
                begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    // occupied cells form a contiguous run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid & (cell_valid + 1'b1)) == '0))
        else $error("cell valid bits not contiguous");

    // a dropped transaction is always reported
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && full) |=> overflow_reg)
        else $error("drop not flagged");

    // the batch-ending transaction always leaves at least one result
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && batch_end) |=> out_valid)
        else $error("no result after batch end");

    // after the final result the chain is empty and the flag cleared
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && final_result) |=> (!cell_valid[0] && !overflow_reg && in_ready))
        else $error("chain not empty after final result");

    // neighbouring occupied cells stay in ascending order
    generate
        for (gi = 0; gi < CAPACITY-1; gi++)
        begin : g_order_chk
            a_order: assert property (@(posedge clk) disable iff (!rst_n)
                cell_valid[gi+1] |-> (cell_val[gi] <= cell_val[gi+1]))
                else $error("chain out of order");
        end
    endgenerate

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ascending value sorter: batches of signed words
// are streamed in, a local sort predicts the ordered output of every batch,
// and each result transaction is checked against it field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAPACITY    = avs_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 20;

    typedef logic signed [avs_pkg::WORD_W-1:0] word_t;

    localparam word_t WORD_MAX = word_t'(32'h7fff_ffff);
    localparam word_t WORD_MIN = word_t'(32'h8000_0000);

    // flavour of random content within one batch
    typedef enum int {
        MIX_FULL_RANGE,
        MIX_NARROW,
        MIX_EDGES
    } value_mix_t;

    typedef struct {
        word_t word;
        logic  last;
        logic  dropped;
    } sorted_entry_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    word_t  value;
    logic   batch_end;
    logic   out_valid;
    logic   out_ready;
    word_t  sorted_value;
    logic   final_result;
    logic   overflowed;

    // predictor state
    word_t          pending_batch[$];
    logic           batch_dropped;
    sorted_entry_t  sorted_expected[$];

    int mismatch_count;
    int idle_cycles;
    int items_accepted;
    int batches_done;
    int results_checked;
    int overflow_batches;
    bit no_idle;

    ascending_value_sorter #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .batch_end    (batch_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .final_result (final_result),
        .overflowed   (overflowed)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        begin
            if (mismatch_count < 50)
                $display("MISMATCH @%0t: %s", $time, msg);
            mismatch_count++;
        end
    endtask

    // prediction of accepted transactions and checking of results
    always @(posedge clk)
    begin : scoreboard
        sorted_entry_t want;
        word_t         held;
        int            i;
        int            j;
        bit            moved;
        moved = 1'b0;
        if (!rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            // input side: store or drop, sort on the batch end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                items_accepted++;
                if (pending_batch.size() < CAPACITY)
                    pending_batch.push_back(value);
                else
                    batch_dropped = 1'b1;
                if (batch_end)
                begin
                    for (i = 1; i < pending_batch.size(); i++)
                    begin
                        held = pending_batch[i];
                        j = i;
                        while (j > 0 && pending_batch[j-1] > held)
                        begin
                            pending_batch[j] = pending_batch[j-1];
                            j--;
                        end
                        pending_batch[j] = held;
                    end
                    for (i = 0; i < pending_batch.size(); i++)
                    begin
                        want.word    = pending_batch[i];
                        want.last    = (i == pending_batch.size() - 1);
                        want.dropped = batch_dropped;
                        sorted_expected.push_back(want);
                    end
                    batches_done++;
                    if (batch_dropped)
                        overflow_batches++;
                    pending_batch.delete();
                    batch_dropped = 1'b0;
                end
            end

            // output side: compare with the oldest expectation
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (sorted_expected.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result value=%0d final=%b ovf=%b",
                                              sorted_value, final_result, overflowed));
                end
                else
                begin
                    want = sorted_expected.pop_front();
                    results_checked++;
                    if (sorted_value !== want.word)
                        report_mismatch($sformatf("sorted_value got %0d want %0d",
                                                  sorted_value, want.word));
                    if (final_result !== want.last)
                        report_mismatch($sformatf("final_result got %b want %b (value %0d)",
                                                  final_result, want.last, want.word));
                    if (overflowed !== want.dropped)
                        report_mismatch($sformatf("overflowed got %b want %b (value %0d)",
                                                  overflowed, want.dropped, want.word));
                end
            end

            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // receiver: ready stretches broken by random stall bursts unless no_idle is set
    initial
    begin : receiver
        int run_len;
        int stall_len;
        out_ready = 1'b0;
        forever
        begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 40);
            @(negedge clk);
            out_ready = 1'b1;
            repeat (run_len - 1) @(negedge clk);
            if (!no_idle)
            begin
                stall_len = $urandom_range(1, 19);
                @(negedge clk);
                out_ready = 1'b0;
                repeat (stall_len - 1) @(negedge clk);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin : watchdog
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // one input transaction, optionally after a random idle burst
    task automatic send_item(input word_t v, input logic last);
        int gap;
        begin
            if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 19);
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            in_valid  = 1'b1;
            value     = v;
            batch_end = last;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
    endtask

    // drop valid and hold off until every predicted result has arrived
    task automatic wait_for_results();
        begin
            @(negedge clk);
            in_valid = 1'b0;
            while (sorted_expected.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic word_t pick_value(input value_mix_t mix);
        begin
            case (mix)
                MIX_NARROW:
                    return word_t'(int'($urandom_range(0, 6)) - 3);
                MIX_EDGES:
                    case ($urandom_range(0, 4))
                        0:       return WORD_MIN;
                        1:       return WORD_MAX;
                        2:       return word_t'(0);
                        3:       return word_t'(-1);
                        default: return word_t'($urandom);
                    endcase
                default:
                    return word_t'($urandom);
            endcase
        end
    endfunction

    // extremes of the signed range in scrambled order
    task automatic test_signed_extremes();
        word_t vals[8];
        begin
            vals = '{WORD_MAX, WORD_MIN, 0, -1, 1, WORD_MIN + 1, WORD_MAX - 1,
                     word_t'(32'h5555_5555)};
            foreach (vals[i])
                send_item(vals[i], i == 7);
            wait_for_results();
        end
    endtask

    // batches holding one element only
    task automatic test_single_element();
        begin
            send_item(WORD_MIN, 1'b1);
            send_item(WORD_MAX, 1'b1);
            wait_for_results();
        end
    endtask

    // duplicates must come out side by side
    task automatic test_equal_values();
        word_t vals[6];
        begin
            vals = '{5, -5, 5, 5, -5, 0};
            foreach (vals[i])
                send_item(vals[i], i == 5);
            repeat (3) send_item(word_t'(32'hdead_beef), 1'b0);
            send_item(word_t'(32'hdead_beef), 1'b1);
            wait_for_results();
        end
    endtask

    // exactly full store, fed in descending order
    task automatic test_full_store();
        word_t v;
        begin
            v = WORD_MAX;
            for (int i = 0; i < CAPACITY; i++)
            begin
                v = v - word_t'($urandom_range(1, 1 << 20));
                send_item(v, i == CAPACITY - 1);
            end
            wait_for_results();
        end
    endtask

    // values past the capacity are dropped, batch end may itself be dropped
    task automatic test_overflow_drops();
        begin
            for (int i = 0; i < CAPACITY + 5; i++)
                send_item(pick_value(MIX_FULL_RANGE), i == CAPACITY + 4);
            for (int i = 0; i < CAPACITY + 1; i++)
                send_item(pick_value(MIX_EDGES), i == CAPACITY);
            // the flag must be clear again on the next batch
            send_item(pick_value(MIX_NARROW), 1'b0);
            send_item(pick_value(MIX_NARROW), 1'b1);
            wait_for_results();
        end
    endtask

    // random batches, mostly short, some long and a few overflowing
    task automatic test_random_batches(input int item_budget);
        int         sent;
        int         len;
        int         pick;
        value_mix_t mix;
        begin
            sent = 0;
            while (sent < item_budget)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    len = $urandom_range(1, 12);
                else if (pick < 9)
                    len = $urandom_range(13, CAPACITY);
                else
                    len = $urandom_range(CAPACITY + 1, CAPACITY + 12);
                mix = value_mix_t'($urandom_range(0, 2));
                for (int k = 0; k < len; k++)
                    send_item(pick_value(mix), k == len - 1);
                sent += len;
            end
            wait_for_results();
        end
    endtask

    // sender waits for the whole output of each batch before the next
    task automatic test_drain_pause();
        int len;
        begin
            repeat (5)
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_item(pick_value(MIX_FULL_RANGE), k == len - 1);
                wait_for_results();
            end
        end
    endtask

    // full rate on both sides, batches sent back to back
    task automatic test_back_to_back();
        int len;
        begin
            no_idle = 1'b1;
            repeat (8)
            begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    send_item(pick_value(value_mix_t'($urandom_range(0, 2))), k == len - 1);
            end
            wait_for_results();
        end
    endtask

    // main sequence
    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        value            = '0;
        batch_end        = 1'b0;
        batch_dropped    = 1'b0;
        no_idle          = 1'b0;
        mismatch_count   = 0;
        idle_cycles      = 0;
        items_accepted   = 0;
        batches_done     = 0;
        results_checked  = 0;
        overflow_batches = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_signed_extremes();
        test_single_element();
        test_equal_values();
        test_full_store();
        test_overflow_drops();
        test_random_batches(165);
        test_drain_pause();
        test_back_to_back();

        wait_for_results();
        repeat (SETTLE_CYC) @(posedge clk);
        if (sorted_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", sorted_expected.size()));

        $display("Run covered %0d input transactions in %0d batches, %0d sorted results checked,",
                 items_accepted, batches_done, results_checked);
        $display("including %0d batches that ran past the %0d-entry store",
                 overflow_batches, CAPACITY);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
